// ----- rtl/trd_pkg.sv -----
// Package for the touch report decoder: beat types, field codes and defaults.
// No dependencies; used by trd_time_scale and touch_report_decoder.
`timescale 1ns / 1ps

package trd_pkg;

   localparam int MAX_FINGERS_DEF  = 5;
   localparam int REPORT_BYTES_DEF = 32;
   localparam int TIME_UNIT_DEF    = 100;

   localparam logic [3:0] ID_LIMIT          = 4'd5;
   localparam logic [7:0] PRESSURE_MIN      = 8'd25;
   localparam logic [7:0] PRESSURE_FULL     = 8'd255;
   localparam logic [8:0] PRESSURE_FULL_OUT = 9'd281;

   localparam logic [1:0] FLAG_DOWN    = 2'd0;
   localparam logic [1:0] FLAG_CONTACT = 2'd2;

   // byte phases inside one finger slot
   localparam logic [2:0] PHASE_FIRST    = 3'd0;
   localparam logic [2:0] PHASE_PRESSURE = 3'd4;
   localparam logic [2:0] PHASE_LAST     = 3'd5;

   typedef struct packed {
      logic [7:0]  report_byte;
      logic        start_of_report;
      logic [31:0] capture_ticks;
   } req_type;

   typedef struct packed {
      logic        is_summary;
      logic [2:0]  finger_id;
      logic        tip_down;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic [8:0]  touch_pressure;
      logic [2:0]  finger_count;
      logic [7:0]  button_state;
      logic [15:0] time_stamp;
      logic        last_of_report;
   } rsp_type;

endpackage

// ----- rtl/touch_report_decoder.sv -----
// Touch report decoder top level: byte position tracking, slot decode, result register.
// Depends on trd_pkg and trd_time_scale.
`timescale 1ns / 1ps

// Usage:
//   req channel carries one report byte per beat, with a start mark and the
//   capture tick count (sampled on byte 0). rsp channel carries at most one
//   result per request beat: a finger record on a slot's pressure byte, or
//   the summary on the last byte of the report.
//   A beat passes an input register, one level of decode logic and the
//   result register on its way from req acceptance to rsp_valid.
//   Throughput is 1 beat per cycle while rsp_stall holds no pending result; the position counter and slot phase
//   counter carry the report layout from beat to beat.
//   The timestamp comes from a 3-register reciprocal multiplier fed by the
//   held ticks; it settles well before the last byte of any report.
//   When rsp_stall holds a pending result, the input register keeps its beat
//   and req_stall rises only if that register is also full.
//   Reset clears the position (next beat is byte 0), counters, stop flag,
//   button byte, held ticks and both valid flags.
module touch_report_decoder #(
   parameter int MAX_FINGERS  = trd_pkg::MAX_FINGERS_DEF,
   parameter int REPORT_BYTES = trd_pkg::REPORT_BYTES_DEF,
   parameter int TIME_UNIT    = trd_pkg::TIME_UNIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  trd_pkg::req_type req_beat,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output trd_pkg::rsp_type rsp_beat
);

   import trd_pkg::*;

   localparam int PosW = $clog2(REPORT_BYTES);
   localparam int CntW = $clog2(MAX_FINGERS + 1);
   localparam logic [PosW-1:0] PosLast = PosW'(REPORT_BYTES - 1);
   localparam logic [PosW-1:0] PosSlot0 = PosW'(2);

   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_beat_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_beat_ff, rsp_beat_in;

   logic [PosW-1:0] pos_ff, pos_in;
   logic [PosW-1:0] slot_ff, slot_in;
   logic [2:0]      phase_ff, phase_in;
   logic [7:0]      button_ff, button_in;
   logic            stopped_ff, stopped_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0]     held_ff, held_in;
   logic [3:0][7:0] slot_bytes_ff, slot_bytes_in;

   logic            out_hold, fire, req_take;
   logic [PosW-1:0] pos_eff;
   logic            is_first, is_last, in_slots, emit;
   logic [7:0]      b;
   logic [3:0]      id;
   logic [1:0]      flag;
   logic [8:0]      pressure;
   logic [15:0]     time_stamp;

   trd_time_scale #(
      .TIME_UNIT(TIME_UNIT)
   ) u_time_scale (
      .clock(clock),
      .held_ticks(held_ff),
      .time_stamp(time_stamp)
   );

   assign out_hold  = rsp_valid_ff && rsp_stall;
   assign fire      = s1_valid_ff && !out_hold;
   assign req_stall = s1_valid_ff && out_hold;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      b        = s1_beat_ff.report_byte;
      pos_eff  = s1_beat_ff.start_of_report ? '0 : pos_ff;
      is_first = (pos_eff == '0);
      is_last  = (pos_eff == PosLast);
      in_slots = (pos_eff >= PosSlot0) && (32'(slot_ff) < 32'(MAX_FINGERS)) && !is_last;
      id       = slot_bytes_ff[2][7:4];
      flag     = slot_bytes_ff[0][7:6];

      if (b < PRESSURE_MIN) begin
         pressure = 9'(PRESSURE_MIN);
      end else if (b == PRESSURE_FULL) begin
         pressure = PRESSURE_FULL_OUT;
      end else begin
         pressure = 9'(b);
      end

      pos_in        = pos_ff;
      slot_in       = slot_ff;
      phase_in      = phase_ff;
      button_in     = button_ff;
      stopped_in    = stopped_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      slot_bytes_in = slot_bytes_ff;
      emit          = 1'b0;
      rsp_beat_in   = '0;

      if (fire) begin
         if (is_first) begin
            held_in    = s1_beat_ff.capture_ticks;
            button_in  = b;
            count_in   = '0;
            stopped_in = 1'b0;
         end

         if (is_last) begin
            emit                       = 1'b1;
            rsp_beat_in.is_summary     = 1'b1;
            rsp_beat_in.finger_count   = 3'(count_ff);
            rsp_beat_in.button_state   = (count_ff != '0) ? button_ff : 8'd0;
            rsp_beat_in.time_stamp     = time_stamp;
            rsp_beat_in.last_of_report = 1'b1;
         end else if (in_slots) begin
            if (phase_ff < PHASE_PRESSURE) begin
               slot_bytes_in[phase_ff[1:0]] = b;
            end else if (phase_ff == PHASE_PRESSURE && !stopped_ff) begin
               if (id >= ID_LIMIT) begin
                  stopped_in = 1'b1;
               end else begin
                  emit                  = 1'b1;
                  rsp_beat_in.finger_id = id[2:0];
                  if (flag inside {FLAG_DOWN, FLAG_CONTACT}) begin
                     rsp_beat_in.tip_down       = 1'b1;
                     rsp_beat_in.pos_x          = {slot_bytes_ff[0][3:0], slot_bytes_ff[1]};
                     rsp_beat_in.pos_y          = {slot_bytes_ff[2][3:0], slot_bytes_ff[3]};
                     rsp_beat_in.touch_pressure = pressure;
                  end
                  count_in = count_ff + CntW'(1);
               end
            end
         end

         // advance position, slot index and slot phase
         pos_in = is_last ? '0 : pos_eff + PosW'(1);
         if (pos_in == PosSlot0) begin
            slot_in  = '0;
            phase_in = PHASE_FIRST;
         end else if (phase_ff == PHASE_LAST) begin
            slot_in  = slot_ff + PosW'(1);
            phase_in = PHASE_FIRST;
         end else begin
            phase_in = phase_ff + 3'd1;
         end
      end

      s1_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = fire ? emit : out_hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         slot_ff      <= '0;
         phase_ff     <= PHASE_FIRST;
         button_ff    <= '0;
         stopped_ff   <= 1'b0;
         count_ff     <= '0;
         held_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         slot_ff      <= slot_in;
         phase_ff     <= phase_in;
         button_ff    <= button_in;
         stopped_ff   <= stopped_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_bytes_ff <= slot_bytes_in;
      if (req_take) begin
         s1_beat_ff <= req_beat;
      end
      if (fire && emit) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ----- rtl/trd_time_scale.sv -----
// Timestamp scaler: held capture ticks divided by the time unit, low 16 bits.
// Reciprocal multiply in two partial products; takes its default from trd_pkg.
`timescale 1ns / 1ps

module trd_time_scale #(
   parameter int TIME_UNIT = trd_pkg::TIME_UNIT_DEF
) (
   input  logic        clock,
   input  logic [31:0] held_ticks,
   output logic [15:0] time_stamp
);

   localparam int ShiftL = $clog2(TIME_UNIT);
   localparam logic [63:0] RecipFull =
      ((64'd1 << (32 + ShiftL)) + 64'(TIME_UNIT) - 64'd1) / 64'(TIME_UNIT);
   localparam logic [15:0] RecipLo = RecipFull[15:0];
   localparam logic [16:0] RecipHi = RecipFull[32:16];
   localparam int SumW = (48 + ShiftL > 65) ? 48 + ShiftL : 65;

   logic [47:0]     prod_lo_ff, prod_lo_in;
   logic [48:0]     prod_hi_ff, prod_hi_in;
   logic [SumW-1:0] sum_ff, sum_in;

   always_comb begin
      prod_lo_in = 48'(held_ticks) * 48'(RecipLo);
      prod_hi_in = 49'(held_ticks) * 49'(RecipHi);
      sum_in     = SumW'(prod_lo_ff) + (SumW'(prod_hi_ff) << 16);
   end

   always_ff @(posedge clock) begin
      prod_lo_ff <= prod_lo_in;
      prod_hi_ff <= prod_hi_in;
      sum_ff     <= sum_in;
   end

   assign time_stamp = sum_ff[32 + ShiftL +: 16];

endmodule
